[src/position_velocity_bias_kalman_macros.svh]
// assertion macros for the position, velocity and bias filter
`ifndef POSITION_VELOCITY_BIAS_KALMAN_MACROS_SVH
`define POSITION_VELOCITY_BIAS_KALMAN_MACROS_SVH
`ifndef ASSERT_OFF
`define PVBK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pvbk assertion failed");
`define PVBK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvbk assertion failed");
`else
`define PVBK_ASSERT(lbl, prop)
`define PVBK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/pvbk_pkg.sv]
// package: types, constants, micro-program and arithmetic helpers of the filter
`timescale 1ns / 1ps
package pvbk_pkg;

    localparam int FRAC_BITS = 32;
    localparam int VAL_W     = 48;
    localparam int ACC_W     = 52;
    localparam int HALF_W    = VAL_W / 2;
    localparam int MAG_W     = 2 * VAL_W;
    localparam int DIV_W     = VAL_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int ADDR_W    = 5;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int SRC_W     = ADDR_W + 1;
    localparam int PC_W      = 8;
    localparam int OP_W      = 4;
    localparam int CFG_IDX_W = 3;
    localparam int QW        = 47;
    localparam int DTW       = 33;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        val_t measured_position;
        val_t measured_accel;
    } in_item_t;

    typedef struct packed {
        val_t position_estimate;
        val_t velocity_estimate;
        val_t bias_estimate;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        val_t              data;
    } wr_req_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SRC_W-1:0]  src_a;
        logic [SRC_W-1:0]  src_b;
        logic [ADDR_W-1:0] dst;
    } uop_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam val_t ONE_Q   = VAL_W'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_HI = {{(ACC_W-VAL_W){1'b0}}, VAL_MAX};
    localparam logic signed [ACC_W-1:0] ACC_LO = {{(ACC_W-VAL_W){1'b1}}, VAL_MIN};

    localparam logic [63:0] QP_RESET64 = ((64'd2 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] QV_RESET64 = ((64'd4 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] QB_RESET64 = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] DT_RESET64 = ((64'd1 << FRAC_BITS) + 64'd100) / 64'd200;
    localparam logic [QW-1:0]  QP_RESET = QP_RESET64[QW-1:0];
    localparam logic [QW-1:0]  QV_RESET = QV_RESET64[QW-1:0];
    localparam logic [QW-1:0]  QB_RESET = QB_RESET64[QW-1:0];
    localparam logic [QW-1:0]  RP_RESET = QB_RESET64[QW-1:0];
    localparam logic [DTW-1:0] DT_RESET = DT_RESET64[DTW-1:0];

    localparam logic [CFG_IDX_W-1:0] CFG_QP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DT = 3'd5;

    localparam logic [OP_W-1:0] OP_LDA  = 4'd0;
    localparam logic [OP_W-1:0] OP_ADDA = 4'd1;
    localparam logic [OP_W-1:0] OP_SUBA = 4'd2;
    localparam logic [OP_W-1:0] OP_ADDH = 4'd3;
    localparam logic [OP_W-1:0] OP_SUBH = 4'd4;
    localparam logic [OP_W-1:0] OP_ST   = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd7;
    localparam logic [OP_W-1:0] OP_END  = 4'd8;

    localparam logic [SRC_W-1:0] SRC_DT   = 6'd32;
    localparam logic [SRC_W-1:0] SRC_C    = 6'd33;
    localparam logic [SRC_W-1:0] SRC_QP   = 6'd34;
    localparam logic [SRC_W-1:0] SRC_QV   = 6'd35;
    localparam logic [SRC_W-1:0] SRC_QB   = 6'd36;
    localparam logic [SRC_W-1:0] SRC_R    = 6'd37;
    localparam logic [SRC_W-1:0] SRC_Z    = 6'd38;
    localparam logic [SRC_W-1:0] SRC_A    = 6'd39;
    localparam logic [SRC_W-1:0] SRC_ZERO = 6'd40;

    localparam logic [ADDR_W-1:0] A_P0   = 5'd0;
    localparam logic [ADDR_W-1:0] A_P1   = 5'd1;
    localparam logic [ADDR_W-1:0] A_P2   = 5'd2;
    localparam logic [ADDR_W-1:0] A_P3   = 5'd3;
    localparam logic [ADDR_W-1:0] A_P4   = 5'd4;
    localparam logic [ADDR_W-1:0] A_P5   = 5'd5;
    localparam logic [ADDR_W-1:0] A_P6   = 5'd6;
    localparam logic [ADDR_W-1:0] A_P7   = 5'd7;
    localparam logic [ADDR_W-1:0] A_P8   = 5'd8;
    localparam logic [ADDR_W-1:0] A_POS  = 5'd9;
    localparam logic [ADDR_W-1:0] A_VEL  = 5'd10;
    localparam logic [ADDR_W-1:0] A_BIAS = 5'd11;
    localparam logic [ADDR_W-1:0] A_S    = 5'd12;
    localparam logic [ADDR_W-1:0] A_M1   = 5'd13;
    localparam logic [ADDR_W-1:0] A_M2   = 5'd14;
    localparam logic [ADDR_W-1:0] A_M3   = 5'd15;
    localparam logic [ADDR_W-1:0] A_T    = 5'd16;
    localparam logic [ADDR_W-1:0] A_D0   = 5'd17;
    localparam logic [ADDR_W-1:0] A_D1   = 5'd18;
    localparam logic [ADDR_W-1:0] A_D2   = 5'd19;
    localparam logic [ADDR_W-1:0] A_D3   = 5'd20;
    localparam logic [ADDR_W-1:0] A_D4   = 5'd21;
    localparam logic [ADDR_W-1:0] A_D5   = 5'd22;
    localparam logic [ADDR_W-1:0] A_D6   = 5'd23;
    localparam logic [ADDR_W-1:0] A_D7   = 5'd24;
    localparam logic [ADDR_W-1:0] A_D8   = 5'd25;
    localparam logic [ADDR_W-1:0] A_M8   = 5'd26;
    localparam logic [ADDR_W-1:0] A_U0   = 5'd27;
    localparam logic [ADDR_W-1:0] A_U1   = 5'd28;
    localparam logic [ADDR_W-1:0] A_U2   = 5'd29;
    localparam logic [ADDR_W-1:0] A_T1   = 5'd30;
    localparam logic [ADDR_W-1:0] A_T2   = 5'd31;
    // reused scratch in the correction phase
    localparam logic [ADDR_W-1:0] A_E    = 5'd12;
    localparam logic [ADDR_W-1:0] A_K0   = 5'd13;
    localparam logic [ADDR_W-1:0] A_ERR  = 5'd17;

    localparam logic [PC_W-1:0] PC_PUPD = 8'd58;
    localparam logic [PC_W-1:0] PC_SUPD = 8'd109;
    localparam logic [PC_W-1:0] PC_PCOR = 8'd121;
    localparam logic [PC_W-1:0] PC_END  = 8'd157;
    localparam logic [PC_W-1:0] BLK9    = 8'd36;
    localparam logic [PC_W-1:0] BLK3    = 8'd12;

    function automatic logic [VAL_W-1:0] mag(input val_t v);
        mag = v[VAL_W-1] ? VAL_W'(~v + 1'b1) : VAL_W'(v);
    endfunction

    function automatic val_t sat_acc(input logic signed [ACC_W-1:0] v);
        if (v > ACC_HI)
            sat_acc = VAL_MAX;
        else if (v < ACC_LO)
            sat_acc = VAL_MIN;
        else
            sat_acc = v[VAL_W-1:0];
    endfunction

    function automatic val_t sat_mag(input logic [MAG_W-1:0] m, input logic neg);
        if (neg)
        begin
            if ((|m[MAG_W-1:VAL_W]) || (m[VAL_W-1] && (|m[VAL_W-2:0])))
                sat_mag = VAL_MIN;
            else
                sat_mag = VAL_W'(~m[VAL_W-1:0] + 1'b1);
        end
        else
        begin
            if (|m[MAG_W-1:VAL_W-1])
                sat_mag = VAL_MAX;
            else
                sat_mag = m[VAL_W-1:0];
        end
    endfunction

    function automatic val_t reset_value(input logic [ADDR_W-1:0] a);
        if (a == A_P0 || a == A_P4 || a == A_P8)
            reset_value = ONE_Q;
        else
            reset_value = '0;
    endfunction

    function automatic logic [SRC_W-1:0] msrc(input logic [ADDR_W-1:0] a);
        msrc = {1'b0, a};
    endfunction

    function automatic uop_t mk(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] a,
                                input logic [SRC_W-1:0] b, input logic [ADDR_W-1:0] d);
        mk = '{op: op, src_a: a, src_b: b, dst: d};
    endfunction

    function automatic uop_t u_op1(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] a);
        u_op1 = mk(op, a, SRC_ZERO, A_P0);
    endfunction

    function automatic uop_t u_st(input logic [ADDR_W-1:0] d);
        u_st = mk(OP_ST, SRC_ZERO, SRC_ZERO, d);
    endfunction

    function automatic uop_t u_mul(input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                   input logic [ADDR_W-1:0] d);
        u_mul = mk(OP_MUL, a, b, d);
    endfunction

    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t              u;
        logic [PC_W-1:0]   k;
        logic [3:0]        j;
        logic [1:0]        s;
        logic [ADDR_W-1:0] r;
        logic [ADDR_W-1:0] tc;
        u  = mk(OP_END, SRC_ZERO, SRC_ZERO, A_P0);
        k  = '0;
        r  = '0;
        tc = A_U0;
        if (pc >= PC_PUPD && pc < PC_PUPD + BLK9)
        begin
            // covariance prediction, one entry in four steps
            k = pc - PC_PUPD;
            j = k[5:2];
            s = k[1:0];
            unique case (s)
                2'd0: u = u_mul(msrc(A_D0 + ADDR_W'(j)), SRC_DT, A_T);
                2'd1: u = u_op1(OP_LDA, msrc(ADDR_W'(j)));
                2'd2: u = u_op1(OP_ADDA, msrc(A_T));
                2'd3: u = u_st(ADDR_W'(j));
            endcase
        end
        else if (pc >= PC_SUPD && pc < PC_SUPD + BLK3)
        begin
            // state correction
            k = pc - PC_SUPD;
            j = k[5:2];
            s = k[1:0];
            r = ADDR_W'(j);
            unique case (s)
                2'd0: u = u_mul(msrc(A_K0 + r), msrc(A_ERR), A_T);
                2'd1: u = u_op1(OP_LDA, msrc(A_POS + r));
                2'd2: u = u_op1(OP_ADDA, msrc(A_T));
                2'd3: u = u_st(A_POS + r);
            endcase
        end
        else if (pc >= PC_PCOR && pc < PC_PCOR + BLK9)
        begin
            // covariance correction
            k = pc - PC_PCOR;
            j = k[5:2];
            s = k[1:0];
            priority if (j < 4'd3)
            begin
                r  = '0;
                tc = (j == 4'd0) ? A_U0 : ((j == 4'd1) ? A_T1 : A_T2);
            end
            else if (j < 4'd6)
            begin
                r  = 5'd1;
                tc = (j == 4'd3) ? A_U0 : ((j == 4'd4) ? A_T1 : A_T2);
            end
            else
            begin
                r  = 5'd2;
                tc = (j == 4'd6) ? A_U0 : ((j == 4'd7) ? A_T1 : A_T2);
            end
            unique case (s)
                2'd0: u = u_mul(msrc(A_K0 + r), msrc(tc), A_T);
                2'd1: u = u_op1(OP_LDA, msrc(ADDR_W'(j)));
                2'd2: u = u_op1(OP_SUBA, msrc(A_T));
                2'd3: u = u_st(ADDR_W'(j));
            endcase
        end
        else
        begin
            unique case (pc)
                // prediction of the estimates
                8'd0:   u = u_op1(OP_LDA, SRC_A);
                8'd1:   u = u_op1(OP_SUBA, msrc(A_BIAS));
                8'd2:   u = u_st(A_S);
                8'd3:   u = u_mul(msrc(A_S), SRC_DT, A_M1);
                8'd4:   u = u_op1(OP_LDA, msrc(A_VEL));
                8'd5:   u = u_op1(OP_ADDA, msrc(A_M1));
                8'd6:   u = u_st(A_VEL);
                8'd7:   u = u_mul(msrc(A_M1), SRC_DT, A_M2);
                8'd8:   u = u_mul(msrc(A_VEL), SRC_DT, A_M3);
                8'd9:   u = u_op1(OP_LDA, msrc(A_POS));
                8'd10:  u = u_op1(OP_ADDH, msrc(A_M2));
                8'd11:  u = u_op1(OP_ADDA, msrc(A_M3));
                8'd12:  u = u_st(A_POS);
                // rate terms
                8'd13:  u = u_op1(OP_LDA, msrc(A_P4));
                8'd14:  u = u_op1(OP_SUBH, msrc(A_P6));
                8'd15:  u = u_op1(OP_SUBH, msrc(A_P2));
                8'd16:  u = u_st(A_T);
                8'd17:  u = u_mul(msrc(A_T), SRC_DT, A_T);
                8'd18:  u = u_op1(OP_LDA, SRC_QP);
                8'd19:  u = u_op1(OP_ADDA, msrc(A_P1));
                8'd20:  u = u_op1(OP_ADDA, msrc(A_P3));
                8'd21:  u = u_op1(OP_ADDA, msrc(A_T));
                8'd22:  u = u_st(A_D0);
                8'd23:  u = u_op1(OP_LDA, SRC_ZERO);
                8'd24:  u = u_op1(OP_ADDH, msrc(A_P7));
                8'd25:  u = u_op1(OP_ADDA, msrc(A_P5));
                8'd26:  u = u_st(A_T);
                8'd27:  u = u_mul(msrc(A_T), SRC_DT, A_T);
                8'd28:  u = u_op1(OP_LDA, msrc(A_P4));
                8'd29:  u = u_op1(OP_SUBA, msrc(A_P2));
                8'd30:  u = u_op1(OP_SUBA, msrc(A_T));
                8'd31:  u = u_st(A_D1);
                8'd32:  u = u_mul(msrc(A_P8), SRC_DT, A_M8);
                8'd33:  u = u_op1(OP_LDA, msrc(A_P5));
                8'd34:  u = u_op1(OP_SUBH, msrc(A_M8));
                8'd35:  u = u_st(A_D2);
                8'd36:  u = u_op1(OP_LDA, msrc(A_P7));
                8'd37:  u = u_op1(OP_ADDH, msrc(A_P5));
                8'd38:  u = u_st(A_T);
                8'd39:  u = u_mul(msrc(A_T), SRC_DT, A_T);
                8'd40:  u = u_op1(OP_LDA, msrc(A_P4));
                8'd41:  u = u_op1(OP_SUBA, msrc(A_P6));
                8'd42:  u = u_op1(OP_SUBA, msrc(A_T));
                8'd43:  u = u_st(A_D3);
                8'd44:  u = u_op1(OP_LDA, SRC_QV);
                8'd45:  u = u_op1(OP_SUBA, msrc(A_P7));
                8'd46:  u = u_op1(OP_SUBA, msrc(A_P5));
                8'd47:  u = u_op1(OP_ADDA, msrc(A_M8));
                8'd48:  u = u_st(A_D4);
                8'd49:  u = u_op1(OP_LDA, SRC_ZERO);
                8'd50:  u = u_op1(OP_SUBA, msrc(A_P8));
                8'd51:  u = u_st(A_D5);
                8'd52:  u = u_st(A_D7);
                8'd53:  u = u_op1(OP_LDA, msrc(A_P7));
                8'd54:  u = u_op1(OP_SUBH, msrc(A_M8));
                8'd55:  u = u_st(A_D6);
                8'd56:  u = u_op1(OP_LDA, SRC_QB);
                8'd57:  u = u_st(A_D8);
                // gains
                8'd94:  u = u_mul(SRC_C, msrc(A_P0), A_U0);
                8'd95:  u = u_mul(SRC_C, msrc(A_P3), A_U1);
                8'd96:  u = u_mul(SRC_C, msrc(A_P6), A_U2);
                8'd97:  u = u_mul(SRC_C, msrc(A_P1), A_T1);
                8'd98:  u = u_mul(SRC_C, msrc(A_P2), A_T2);
                8'd99:  u = u_mul(SRC_C, msrc(A_U0), A_T);
                8'd100: u = u_op1(OP_LDA, SRC_R);
                8'd101: u = u_op1(OP_ADDA, msrc(A_T));
                8'd102: u = u_st(A_E);
                8'd103: u = mk(OP_DIV, msrc(A_U0), msrc(A_E), A_K0);
                8'd104: u = mk(OP_DIV, msrc(A_U1), msrc(A_E), A_K0 + 5'd1);
                8'd105: u = mk(OP_DIV, msrc(A_U2), msrc(A_E), A_K0 + 5'd2);
                8'd106: u = u_op1(OP_LDA, SRC_Z);
                8'd107: u = u_op1(OP_SUBA, msrc(A_POS));
                8'd108: u = u_st(A_ERR);
                default: u = mk(OP_END, SRC_ZERO, SRC_ZERO, A_P0);
            endcase
        end
        uop_rom = u;
    endfunction

endpackage

[src/pvbk_regfile.sv]
// state and scratch memory: two registered read ports, one write port
`timescale 1ns / 1ps
module pvbk_regfile
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pvbk_pkg::ADDR_W-1:0]   rd_addr_a,
    input  logic [pvbk_pkg::ADDR_W-1:0]   rd_addr_b,
    output pvbk_pkg::val_t                rd_data_a,
    output pvbk_pkg::val_t                rd_data_b,
    input  pvbk_pkg::wr_req_t             wr
);

    logic [pvbk_pkg::VAL_W-1:0]  mem [pvbk_pkg::DEPTH];
    logic [pvbk_pkg::VAL_W-1:0]  data_a_reg;
    logic [pvbk_pkg::VAL_W-1:0]  data_b_reg;
    logic [pvbk_pkg::ADDR_W-1:0] addr_a_reg;
    logic [pvbk_pkg::ADDR_W-1:0] addr_b_reg;
    logic [pvbk_pkg::DEPTH-1:0]  valid_reg;
    logic                        va_reg;
    logic                        vb_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        data_a_reg <= mem[rd_addr_a];
        data_b_reg <= mem[rd_addr_b];
        addr_a_reg <= rd_addr_a;
        addr_b_reg <= rd_addr_b;
    end

    // entries not yet written read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            va_reg <= valid_reg[rd_addr_a];
            vb_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = va_reg ? data_a_reg : pvbk_pkg::reset_value(addr_a_reg);
    assign rd_data_b = vb_reg ? data_b_reg : pvbk_pkg::reset_value(addr_b_reg);

endmodule

[src/pvbk_mul.sv]
// fixed-point multiplier: four half-width partial products, then scale and saturate
`timescale 1ns / 1ps
module pvbk_mul
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pvbk_pkg::val_t  a,
    input  pvbk_pkg::val_t  b,
    output logic            done,
    output pvbk_pkg::val_t  prod
);

    logic [pvbk_pkg::VAL_W-1:0]  x_reg;
    logic [pvbk_pkg::VAL_W-1:0]  y_reg;
    logic                        neg_reg;
    logic [pvbk_pkg::MAG_W-1:0]  acc_reg;
    logic [1:0]                  step_reg;
    logic                        busy_reg;
    logic                        fin_reg;
    logic                        done_reg;
    pvbk_pkg::val_t              prod_reg;
    logic [pvbk_pkg::HALF_W-1:0] xs;
    logic [pvbk_pkg::HALF_W-1:0] ys;
    logic [pvbk_pkg::VAL_W-1:0]  pp;
    logic [pvbk_pkg::MAG_W-1:0]  pp_ext;
    logic [pvbk_pkg::MAG_W-1:0]  pp_sh;

    always_comb
    begin
        xs     = step_reg[0] ? x_reg[pvbk_pkg::VAL_W-1:pvbk_pkg::HALF_W]
                             : x_reg[pvbk_pkg::HALF_W-1:0];
        ys     = step_reg[1] ? y_reg[pvbk_pkg::VAL_W-1:pvbk_pkg::HALF_W]
                             : y_reg[pvbk_pkg::HALF_W-1:0];
        pp     = pvbk_pkg::VAL_W'(xs * ys);
        pp_ext = pvbk_pkg::MAG_W'(pp);
        unique case (step_reg)
            2'd0:       pp_sh = pp_ext;
            2'd1, 2'd2: pp_sh = pp_ext << pvbk_pkg::HALF_W;
            2'd3:       pp_sh = pp_ext << (2 * pvbk_pkg::HALF_W);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= pvbk_pkg::mag(a);
            y_reg   <= pvbk_pkg::mag(b);
            neg_reg <= a[pvbk_pkg::VAL_W-1] ^ b[pvbk_pkg::VAL_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp_sh;
        if (fin_reg)
            prod_reg <= pvbk_pkg::sat_mag(acc_reg >> pvbk_pkg::FRAC_BITS, neg_reg);
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

[src/pvbk_div.sv]
// restoring divider for the gains, one quotient bit a cycle
`timescale 1ns / 1ps
module pvbk_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pvbk_pkg::val_t  num,
    input  pvbk_pkg::val_t  den,
    output logic            done,
    output pvbk_pkg::val_t  quot
);

    logic [pvbk_pkg::DIV_W-1:0]     dv_reg;
    logic [pvbk_pkg::DIV_W-1:0]     q_reg;
    logic [pvbk_pkg::VAL_W-1:0]     y_reg;
    logic [pvbk_pkg::VAL_W-1:0]     r_reg;
    logic                           neg_reg;
    logic                           zero_reg;
    logic [pvbk_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           fin_reg;
    logic                           done_reg;
    pvbk_pkg::val_t                 quot_reg;
    logic [pvbk_pkg::VAL_W:0]       r2;
    logic [pvbk_pkg::VAL_W+1:0]     trial;

    always_comb
    begin
        r2    = {r_reg, dv_reg[pvbk_pkg::DIV_W-1]};
        trial = {1'b0, r2} - {2'b00, y_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= pvbk_pkg::DIV_CNT_W'(pvbk_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pvbk_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dv_reg   <= pvbk_pkg::DIV_W'(pvbk_pkg::mag(num)) << pvbk_pkg::FRAC_BITS;
            y_reg    <= pvbk_pkg::mag(den);
            r_reg    <= '0;
            q_reg    <= '0;
            neg_reg  <= num[pvbk_pkg::VAL_W-1] ^ den[pvbk_pkg::VAL_W-1];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            dv_reg <= dv_reg << 1;
            if (!trial[pvbk_pkg::VAL_W+1])
            begin
                r_reg <= trial[pvbk_pkg::VAL_W-1:0];
                q_reg <= {q_reg[pvbk_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r2[pvbk_pkg::VAL_W-1:0];
                q_reg <= {q_reg[pvbk_pkg::DIV_W-2:0], 1'b0};
            end
        end
        if (fin_reg)
            quot_reg <= zero_reg ? '0
                                 : pvbk_pkg::sat_mag(pvbk_pkg::MAG_W'(q_reg), neg_reg);
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[src/position_velocity_bias_kalman.sv]
// a micro-program of 158 steps runs on a two-read-port state memory, a multiplier
// (34 uses) and a divider (three uses); a new beat is taken only once the last one
// has run, and the next beat is taken while the last result waits
// reset: estimates zero, covariance identity, registers at their reset values
// top level of the position, velocity and bias filter
`timescale 1ns / 1ps
`include "position_velocity_bias_kalman_macros.svh"
module position_velocity_bias_kalman
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  pvbk_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output pvbk_pkg::out_item_t              out_data,
    input  logic                             cfg_wr_en,
    input  logic [pvbk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pvbk_pkg::VAL_W-1:0]       cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_MULW  = 3'd3;
    localparam logic [2:0] S_DIVW  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                          state_reg, state_next;
    logic [pvbk_pkg::PC_W-1:0]           pc_reg, pc_next;
    logic signed [pvbk_pkg::ACC_W-1:0]   acc_reg, acc_next;
    pvbk_pkg::val_t                      z_reg, a_reg;
    pvbk_pkg::val_t                      pos_reg, pos_next;
    pvbk_pkg::val_t                      vel_reg, vel_next;
    pvbk_pkg::val_t                      bias_reg, bias_next;
    pvbk_pkg::out_item_t                 out_data_reg, out_data_next;
    logic                                out_valid_reg, out_valid_next;
    logic [pvbk_pkg::QW-1:0]             qp_reg, qv_reg, qb_reg, rp_reg;
    pvbk_pkg::val_t                      c_reg;
    logic [pvbk_pkg::DTW-1:0]            dt_reg;

    pvbk_pkg::uop_t                      u;
    pvbk_pkg::val_t                      rd_a, rd_b, opa, opb;
    pvbk_pkg::wr_req_t                   wr;
    logic                                mul_start, mul_done, div_start, div_done;
    pvbk_pkg::val_t                      mul_prod, div_quot;
    logic signed [pvbk_pkg::ACC_W-1:0]   opx, oph;
    logic                                in_take;

    function automatic pvbk_pkg::val_t pick(
        input logic [pvbk_pkg::SRC_W-1:0] src, input pvbk_pkg::val_t memv,
        input logic [pvbk_pkg::DTW-1:0] dtv, input pvbk_pkg::val_t cv,
        input logic [pvbk_pkg::QW-1:0] qpv, input logic [pvbk_pkg::QW-1:0] qvv,
        input logic [pvbk_pkg::QW-1:0] qbv, input logic [pvbk_pkg::QW-1:0] rv,
        input pvbk_pkg::val_t zv, input pvbk_pkg::val_t av);
        pvbk_pkg::val_t v;
        v = '0;
        if (!src[pvbk_pkg::SRC_W-1])
            v = memv;
        else
        begin
            unique case (src)
                pvbk_pkg::SRC_DT: v = pvbk_pkg::VAL_W'(dtv);
                pvbk_pkg::SRC_C:  v = cv;
                pvbk_pkg::SRC_QP: v = pvbk_pkg::VAL_W'(qpv);
                pvbk_pkg::SRC_QV: v = pvbk_pkg::VAL_W'(qvv);
                pvbk_pkg::SRC_QB: v = pvbk_pkg::VAL_W'(qbv);
                pvbk_pkg::SRC_R:  v = pvbk_pkg::VAL_W'(rv);
                pvbk_pkg::SRC_Z:  v = zv;
                pvbk_pkg::SRC_A:  v = av;
                default:          v = '0;
            endcase
        end
        pick = v;
    endfunction

    assign u        = pvbk_pkg::uop_rom(pc_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    pvbk_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr_a (u.src_a[pvbk_pkg::ADDR_W-1:0]),
        .rd_addr_b (u.src_b[pvbk_pkg::ADDR_W-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr        (wr)
    );

    pvbk_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pvbk_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        opa = pick(u.src_a, rd_a, dt_reg, c_reg, qp_reg, qv_reg, qb_reg, rp_reg, z_reg, a_reg);
        opb = pick(u.src_b, rd_b, dt_reg, c_reg, qp_reg, qv_reg, qb_reg, rp_reg, z_reg, a_reg);
        opx = {{(pvbk_pkg::ACC_W-pvbk_pkg::VAL_W){opa[pvbk_pkg::VAL_W-1]}}, opa};
        oph = {{(pvbk_pkg::ACC_W-pvbk_pkg::VAL_W+1){opa[pvbk_pkg::VAL_W-1]}},
               opa[pvbk_pkg::VAL_W-1:1]};
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        acc_next       = acc_reg;
        wr             = '0;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_FETCH;
                    pc_next    = '0;
                end
            end
            S_FETCH:
                state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_FETCH;
                pc_next    = pc_reg + 1'b1;
                unique case (u.op)
                    pvbk_pkg::OP_LDA:  acc_next = opx;
                    pvbk_pkg::OP_ADDA: acc_next = acc_reg + opx;
                    pvbk_pkg::OP_SUBA: acc_next = acc_reg - opx;
                    pvbk_pkg::OP_ADDH: acc_next = acc_reg + oph;
                    pvbk_pkg::OP_SUBH: acc_next = acc_reg - oph;
                    pvbk_pkg::OP_ST:
                    begin
                        wr.en   = 1'b1;
                        wr.addr = u.dst;
                        wr.data = pvbk_pkg::sat_acc(acc_reg);
                    end
                    pvbk_pkg::OP_MUL:
                    begin
                        mul_start  = 1'b1;
                        state_next = S_MULW;
                        pc_next    = pc_reg;
                    end
                    pvbk_pkg::OP_DIV:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVW;
                        pc_next    = pc_reg;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                        pc_next    = pc_reg;
                    end
                endcase
            end
            S_MULW:
            begin
                if (mul_done)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = u.dst;
                    wr.data    = mul_prod;
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = u.dst;
                    wr.data    = div_quot;
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.position_estimate = pos_reg;
                    out_data_next.velocity_estimate = vel_reg;
                    out_data_next.bias_estimate     = bias_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    pc_next        = '0;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // copies of the three estimates as they are written back
    always_comb
    begin
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        bias_next = bias_reg;
        if (wr.en && wr.addr == pvbk_pkg::A_POS)
            pos_next = wr.data;
        if (wr.en && wr.addr == pvbk_pkg::A_VEL)
            vel_next = wr.data;
        if (wr.en && wr.addr == pvbk_pkg::A_BIAS)
            bias_next = wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            qp_reg        <= pvbk_pkg::QP_RESET;
            qv_reg        <= pvbk_pkg::QV_RESET;
            qb_reg        <= pvbk_pkg::QB_RESET;
            rp_reg        <= pvbk_pkg::RP_RESET;
            c_reg         <= pvbk_pkg::ONE_Q;
            dt_reg        <= pvbk_pkg::DT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    pvbk_pkg::CFG_QP: qp_reg <= cfg_data[pvbk_pkg::QW-1:0];
                    pvbk_pkg::CFG_QV: qv_reg <= cfg_data[pvbk_pkg::QW-1:0];
                    pvbk_pkg::CFG_QB: qb_reg <= cfg_data[pvbk_pkg::QW-1:0];
                    pvbk_pkg::CFG_RP: rp_reg <= cfg_data[pvbk_pkg::QW-1:0];
                    pvbk_pkg::CFG_C:  c_reg  <= cfg_data;
                    pvbk_pkg::CFG_DT: dt_reg <= cfg_data[pvbk_pkg::DTW-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        pos_reg      <= pos_next;
        vel_reg      <= vel_next;
        bias_reg     <= bias_next;
        out_data_reg <= out_data_next;
        if (in_take)
        begin
            z_reg <= in_data.measured_position;
            a_reg <= in_data.measured_accel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `PVBK_ASSERT_NEXT(a_accept_starts, in_take, state_reg == S_FETCH && pc_reg == '0)
    `PVBK_ASSERT(a_mul_done_waits, mul_done |-> state_reg == S_MULW)
    `PVBK_ASSERT(a_div_done_waits, div_done |-> state_reg == S_DIVW)
    `PVBK_ASSERT_NEXT(a_done_delivers, state_reg == S_DONE && !out_stall, out_valid && state_reg == S_IDLE)

endmodule

[sim/position_velocity_bias_kalman_tb.sv]
// self-checking testbench of the position, velocity and bias filter
`timescale 1ns / 1ps
module position_velocity_bias_kalman_tb;

    typedef logic signed [pvbk_pkg::VAL_W-1:0] fx_t;
    typedef logic signed [127:0] wide_t;

    // indexes past the register list, writes are ignored
    localparam logic [pvbk_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [pvbk_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    pvbk_pkg::in_item_t             in_data;
    logic                           out_valid;
    logic                           out_stall;
    pvbk_pkg::out_item_t            out_data;
    logic                           cfg_wr_en;
    logic [pvbk_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pvbk_pkg::VAL_W-1:0]     cfg_data;

    // filter model state
    logic [pvbk_pkg::QW-1:0]  m_qp, m_qv, m_qb, m_rp;
    fx_t                      m_c;
    logic [pvbk_pkg::DTW-1:0] m_dt;
    fx_t                      m_pos, m_vel, m_bias;
    fx_t                      m_cov [9];

    pvbk_pkg::out_item_t estimate_queue [$];
    int        errors;
    int        beats_in;
    int        beats_out;
    bit        idle_off;
    bit        hold_rx;

    position_velocity_bias_kalman DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic fx_t clamp(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = wide_t'(pvbk_pkg::VAL_MAX);
        lo = wide_t'(pvbk_pkg::VAL_MIN);
        if (v > hi)
            return pvbk_pkg::VAL_MAX;
        if (v < lo)
            return pvbk_pkg::VAL_MIN;
        return fx_t'(v);
    endfunction

    function automatic fx_t qmul(input fx_t a, input fx_t b);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        return clamp(p / (wide_t'(1) <<< pvbk_pkg::FRAC_BITS));
    endfunction

    function automatic fx_t qdiv(input fx_t n, input fx_t d);
        if (d == 0)
            return '0;
        return clamp((wide_t'(n) <<< pvbk_pkg::FRAC_BITS) / wide_t'(d));
    endfunction

    function automatic fx_t halve(input fx_t v);
        return v >>> 1;
    endfunction

    task automatic filter_reset();
        m_qp = pvbk_pkg::QP_RESET;
        m_qv = pvbk_pkg::QV_RESET;
        m_qb = pvbk_pkg::QB_RESET;
        m_rp = pvbk_pkg::RP_RESET;
        m_c  = pvbk_pkg::ONE_Q;
        m_dt = pvbk_pkg::DT_RESET;
        m_pos = '0;
        m_vel = '0;
        m_bias = '0;
        for (int i = 0; i < 9; i++)
            m_cov[i] = (i % 4 == 0) ? pvbk_pkg::ONE_Q : '0;
    endtask

    function automatic pvbk_pkg::out_item_t filter_step(input pvbk_pkg::in_item_t s);
        fx_t   dt, acc, e, err;
        fx_t   d [9];
        fx_t   u [3];
        fx_t   t [3];
        fx_t   k [3];
        fx_t   p [9];
        pvbk_pkg::out_item_t r;
        dt = fx_t'({15'd0, m_dt});
        p = m_cov;
        acc = clamp(wide_t'(s.measured_accel) - m_bias);
        m_vel = clamp(wide_t'(m_vel) + qmul(acc, dt));
        m_pos = clamp(wide_t'(m_pos) + halve(qmul(qmul(acc, dt), dt)) + qmul(m_vel, dt));
        d[0] = clamp(wide_t'({1'b0, m_qp}) + p[1] + p[3]
                     + qmul(clamp(wide_t'(p[4]) - halve(p[6]) - halve(p[2])), dt));
        d[1] = clamp(wide_t'(p[4]) - p[2] - qmul(clamp(wide_t'(halve(p[7])) + p[5]), dt));
        d[2] = clamp(wide_t'(p[5]) - halve(qmul(p[8], dt)));
        d[3] = clamp(wide_t'(p[4]) - p[6] - qmul(clamp(wide_t'(p[7]) + halve(p[5])), dt));
        d[4] = clamp(wide_t'({1'b0, m_qv}) - p[7] - p[5] + qmul(p[8], dt));
        d[5] = clamp(-wide_t'(p[8]));
        d[6] = clamp(wide_t'(p[7]) - halve(qmul(p[8], dt)));
        d[7] = d[5];
        d[8] = fx_t'({1'b0, m_qb});
        for (int i = 0; i < 9; i++)
            p[i] = clamp(wide_t'(p[i]) + qmul(d[i], dt));
        for (int i = 0; i < 3; i++)
            u[i] = qmul(m_c, p[i * 3]);
        e = clamp(wide_t'({1'b0, m_rp}) + qmul(m_c, u[0]));
        for (int i = 0; i < 3; i++)
            k[i] = qdiv(u[i], e);
        err = clamp(wide_t'(s.measured_position) - m_pos);
        m_pos = clamp(wide_t'(m_pos) + qmul(k[0], err));
        m_vel = clamp(wide_t'(m_vel) + qmul(k[1], err));
        m_bias = clamp(wide_t'(m_bias) + qmul(k[2], err));
        t[0] = u[0];
        t[1] = qmul(m_c, p[1]);
        t[2] = qmul(m_c, p[2]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i * 3 + j] = clamp(wide_t'(p[i * 3 + j]) - qmul(k[i], t[j]));
        m_cov = p;
        r.position_estimate = m_pos;
        r.velocity_estimate = m_vel;
        r.bias_estimate = m_bias;
        return r;
    endfunction

    task automatic write_reg(input logic [pvbk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pvbk_pkg::VAL_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pvbk_pkg::CFG_QP: m_qp = v[pvbk_pkg::QW-1:0];
            pvbk_pkg::CFG_QV: m_qv = v[pvbk_pkg::QW-1:0];
            pvbk_pkg::CFG_QB: m_qb = v[pvbk_pkg::QW-1:0];
            pvbk_pkg::CFG_RP: m_rp = v[pvbk_pkg::QW-1:0];
            pvbk_pkg::CFG_C:  m_c  = v;
            pvbk_pkg::CFG_DT: m_dt = v[pvbk_pkg::DTW-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (estimate_queue.size() != 0)
            @(posedge clk);
        repeat (900) @(posedge clk);
    endtask

    // one beat; expected result either typed in or from the model
    task automatic send_sample(input pvbk_pkg::in_item_t s, input bit typed,
                               input pvbk_pkg::out_item_t want);
        pvbk_pkg::out_item_t got;
        while (!idle_off && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = filter_step(s);
        estimate_queue.push_back(typed ? want : got);
        beats_in++;
    endtask

    function automatic fx_t rand_fx(input int mode);
        case (mode)
            0: return fx_t'({$urandom, $urandom});
            1: return fx_t'($signed({$urandom}) >>> $urandom_range(0, 31));
            default: return fx_t'($signed($urandom_range(0, 2000)) - 1000) <<< 22;
        endcase
    endfunction

    always @(posedge clk)
    begin
        pvbk_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (estimate_queue.size() == 0)
            begin
                errors++;
                $display("%t unexpected result %h", $realtime, out_data);
            end
            else
            begin
                want = estimate_queue.pop_front();
                if (out_data.position_estimate !== want.position_estimate)
                begin
                    errors++;
                    $display("%t position exp %h got %h", $realtime,
                             want.position_estimate, out_data.position_estimate);
                end
                if (out_data.velocity_estimate !== want.velocity_estimate)
                begin
                    errors++;
                    $display("%t velocity exp %h got %h", $realtime,
                             want.velocity_estimate, out_data.velocity_estimate);
                end
                if (out_data.bias_estimate !== want.bias_estimate)
                begin
                    errors++;
                    $display("%t bias exp %h got %h", $realtime,
                             want.bias_estimate, out_data.bias_estimate);
                end
            end
        end
    end

    // receiver stall, with a long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_rx = 1'b0;
            end
            out_stall <= !idle_off && ($urandom_range(99) < 7);
        end
    end

    initial
    begin
        #800ms;
        $display("position_velocity_bias_kalman: mismatch");
        $finish;
    end

    initial
    begin
        pvbk_pkg::in_item_t  s;
        pvbk_pkg::out_item_t zero_est;
        pvbk_pkg::in_item_t  table_in [$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        idle_off = 1'b0;
        hold_rx = 1'b0;
        filter_reset();
        zero_est = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sample straight after reset gives zero estimates
        send_sample('0, 1'b1, zero_est);
        table_in = '{'{pvbk_pkg::VAL_MAX, pvbk_pkg::VAL_MAX},
                     '{pvbk_pkg::VAL_MIN, pvbk_pkg::VAL_MIN},
                     '{pvbk_pkg::VAL_MAX, pvbk_pkg::VAL_MIN},
                     '{pvbk_pkg::VAL_MIN, pvbk_pkg::VAL_MAX},
                     '{pvbk_pkg::ONE_Q, '0}, '{-pvbk_pkg::ONE_Q, pvbk_pkg::ONE_Q},
                     '{48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA}, '{'0, '0}};
        foreach (table_in[i])
            send_sample(table_in[i], 1'b0, zero_est);
        wait_drained();

        // zero innovation variance: zero gains
        write_reg(pvbk_pkg::CFG_C, '0);
        write_reg(pvbk_pkg::CFG_RP, '0);
        send_sample('{pvbk_pkg::ONE_Q, pvbk_pkg::ONE_Q}, 1'b0, zero_est);
        send_sample('{pvbk_pkg::VAL_MAX, pvbk_pkg::VAL_MIN}, 1'b0, zero_est);
        wait_drained();
        // extreme registers, and two ignored indexes
        write_reg(pvbk_pkg::CFG_QP, {pvbk_pkg::VAL_W{1'b1}});
        write_reg(pvbk_pkg::CFG_QV, {pvbk_pkg::VAL_W{1'b1}});
        write_reg(pvbk_pkg::CFG_QB, {pvbk_pkg::VAL_W{1'b1}});
        write_reg(pvbk_pkg::CFG_RP, {pvbk_pkg::VAL_W{1'b1}});
        write_reg(pvbk_pkg::CFG_C, pvbk_pkg::VAL_MIN);
        write_reg(pvbk_pkg::CFG_DT, {pvbk_pkg::VAL_W{1'b1}});
        write_reg(CFG_SPARE_A, '0);
        write_reg(CFG_SPARE_B, {pvbk_pkg::VAL_W{1'b1}});
        for (int i = 0; i < 4; i++)
            send_sample('{rand_fx(0), rand_fx(0)}, 1'b0, zero_est);
        wait_drained();
        write_reg(pvbk_pkg::CFG_C, pvbk_pkg::VAL_MAX);
        write_reg(pvbk_pkg::CFG_DT, 48'h1_0000_0000);
        for (int i = 0; i < 3; i++)
            send_sample('{rand_fx(1), rand_fx(1)}, 1'b0, zero_est);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(pvbk_pkg::CFG_QP, ph == 0 ? '0 :
                      pvbk_pkg::VAL_W'({$urandom, $urandom} >> $urandom_range(16, 40)));
            write_reg(pvbk_pkg::CFG_QV,
                      pvbk_pkg::VAL_W'({$urandom, $urandom} >> $urandom_range(16, 40)));
            write_reg(pvbk_pkg::CFG_QB,
                      pvbk_pkg::VAL_W'({$urandom, $urandom} >> $urandom_range(16, 40)));
            write_reg(pvbk_pkg::CFG_RP,
                      pvbk_pkg::VAL_W'({$urandom, $urandom} >> $urandom_range(16, 40)));
            write_reg(pvbk_pkg::CFG_C, ph == 1 ? fx_t'(-pvbk_pkg::ONE_Q) : rand_fx(ph % 3));
            write_reg(pvbk_pkg::CFG_DT, ph == 2 ? '0 :
                      pvbk_pkg::VAL_W'({$urandom} >> $urandom_range(0, 12)));
            idle_off = (ph == 3);
            if (ph == 4)
                hold_rx = 1'b1;
            for (int i = 0; i < 100; i++)
            begin
                s.measured_position = rand_fx($urandom_range(0, 2));
                s.measured_accel = rand_fx($urandom_range(0, 2));
                send_sample(s, 1'b0, zero_est);
            end
            wait_drained();
        end

        $display("covered %0d samples and %0d estimates over extreme and random settings",
                 beats_in, beats_out);
        if (errors == 0)
            $display("position_velocity_bias_kalman: match");
        else
            $display("position_velocity_bias_kalman: mismatch");
        $finish;
    end
endmodule
